// ===== rtl/ctma_pkg.sv =====
// Shared types and constants of the calibrated trimmed moving average block.
// Used by the divider, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package ctma_pkg;

  localparam int RAW_W = 16;
  localparam int SCALE_W = 16;
  localparam int DIFF_W = RAW_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int FRAC_BITS = 12;
  localparam int CAL_W = 18;
  localparam int TOT_W = 22;
  localparam int NUM_W = 22;
  localparam int NUM_SW = NUM_W + 1;
  localparam int DIV_W = 5;
  localparam int AXES = 3;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [PROD_W-1:0] CAL_MAX = PROD_W'((1 << (CAL_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] CAL_MIN = -PROD_W'(1 << (CAL_W - 1));

  localparam logic [1:0] MODE_CAL_ONLY = 2'd0;
  localparam logic [1:0] MODE_RESET = MODE_CAL_ONLY;
  localparam logic [3:0] WINDOW_RESET = 4'd5;
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << FRAC_BITS);

  typedef enum logic [2:0] {
    CFG_SMOOTH_MODE = 3'd0,
    CFG_WINDOW_LENGTH = 3'd1,
    CFG_OFFSET_X = 3'd2,
    CFG_OFFSET_Y = 3'd3,
    CFG_OFFSET_Z = 3'd4,
    CFG_SCALE_X = 3'd5,
    CFG_SCALE_Y = 3'd6,
    CFG_SCALE_Z = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic start;
    logic signed [NUM_SW-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [NUM_SW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/ctma_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on ctma_pkg for widths and the request and response structs.
`timescale 1ns / 1ps
`default_nettype none
module ctma_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire ctma_pkg::div_req_t req,
  output ctma_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(ctma_pkg::NUM_W);

  logic busy;
  logic done;
  logic neg;
  logic [CNT_W-1:0] cnt;
  logic [ctma_pkg::NUM_W-1:0] quo;
  logic [ctma_pkg::DIV_W-1:0] rem;
  logic [ctma_pkg::DIV_W-1:0] dvs;
  logic [ctma_pkg::DIV_W:0] shifted;
  logic signed [ctma_pkg::NUM_SW-1:0] mag;

  always_comb begin
    shifted = {rem, quo[ctma_pkg::NUM_W-1]};
    mag = req.dividend[ctma_pkg::NUM_SW-1] ? -req.dividend : req.dividend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= req.dividend[ctma_pkg::NUM_SW-1];
        quo <= mag[ctma_pkg::NUM_W-1:0];
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        if (shifted >= {1'b0, dvs}) begin
          rem <= ctma_pkg::DIV_W'(shifted - {1'b0, dvs});
          quo <= {quo[ctma_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[ctma_pkg::DIV_W-1:0];
          quo <= {quo[ctma_pkg::NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ctma_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule
`default_nettype wire

// ===== rtl/ctma_window.sv =====
// Ring window store: one write and one registered read per cycle, with a
// valid bit per entry so a clear need only reset the valid bits. No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module ctma_window #(
  parameter int DEPTH = 30,
  parameter int DATA_W = 18,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic clear,
  input  wire logic rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic signed [DATA_W-1:0] rd_data,
  input  wire logic wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic signed [DATA_W-1:0] wr_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/calibrated_trimmed_moving_average.sv =====
// Calibrated trimmed moving average: top level with sequencer, shared multiplier and compare.
// Per axis a request runs through S_MUL and S_SAT; the averaging modes add S_OLD, the scan
// of the effective window when trimmed, and the divider; the next request is taken in S_IDLE.
// One request at a time; the divider's wait and the one-entry-a-cycle scan set it.
// Synchronous reset restores the registers and clears window, totals and write slot at once.
// Depends on ctma_pkg, ctma_divider and ctma_window.
`timescale 1ns / 1ps
`default_nettype none
module calibrated_trimmed_moving_average #(
  parameter int WINDOW_MAX = 10
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // raw_x [15:0], raw_y [31:16], raw_z [47:32]
  input  wire logic [47:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // out_x [17:0], out_y [35:18], out_z [53:36], zero [55:54]
  output logic [55:0] m_axis_tdata,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int DEPTH = WINDOW_MAX * ctma_pkg::AXES;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(WINDOW_MAX);
  localparam int WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int CAL_W = ctma_pkg::CAL_W;
  localparam int TOT_W = ctma_pkg::TOT_W;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MUL  = 11'b000_0000_0010,
    S_SAT  = 11'b000_0000_0100,
    S_OLD  = 11'b000_0000_1000,
    S_SCAN = 11'b000_0001_0000,
    S_SEND = 11'b000_0010_0000,
    S_TRIM = 11'b000_0100_0000,
    S_DIVS = 11'b000_1000_0000,
    S_DIVW = 11'b001_0000_0000,
    S_ADV  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [1:0] smooth_mode;
  logic [3:0] window_length;
  logic [ctma_pkg::RAW_W-1:0] offset [ctma_pkg::AXES];
  logic [ctma_pkg::SCALE_W-1:0] scale [ctma_pkg::AXES];

  logic [ctma_pkg::RAW_W-1:0] raw [ctma_pkg::AXES];
  logic signed [TOT_W-1:0] totals [ctma_pkg::AXES];
  logic signed [CAL_W-1:0] res [ctma_pkg::AXES];
  logic [1:0] axis;
  logic [SW-1:0] slot;
  logic [WIN_W-1:0] scan_idx;
  logic scan_pend;
  logic scan_first;
  logic signed [CAL_W-1:0] mx;
  logic signed [CAL_W-1:0] mn;
  logic signed [CAL_W-1:0] mx_next;
  logic signed [CAL_W-1:0] mn_next;
  logic signed [CAL_W-1:0] cal;
  logic signed [TOT_W-1:0] tsum;
  logic signed [ctma_pkg::PROD_W-1:0] prod;
  logic signed [ctma_pkg::NUM_SW-1:0] num;
  logic [ctma_pkg::DIV_W-1:0] divisor;

  logic [WIN_W-1:0] win;
  logic [WIN_W-1:0] slot_inc;
  logic signed [ctma_pkg::DIFF_W-1:0] diff;
  logic signed [ctma_pkg::PROD_W-1:0] prod_b;
  logic signed [ctma_pkg::PROD_W-1:0] quot_q;
  logic signed [CAL_W-1:0] cal_comb;
  logic signed [TOT_W-1:0] total_new;
  logic trimmed;
  logic window_clear;
  logic [AW-1:0] slot_addr;
  logic [AW-1:0] scan_addr;

  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic signed [CAL_W-1:0] rd_data;
  logic wr_en;

  ctma_pkg::div_req_t div_req;
  ctma_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign window_clear = cfg_valid && (cfg_index == ctma_pkg::CFG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_mode <= ctma_pkg::MODE_RESET;
      window_length <= ctma_pkg::WINDOW_RESET;
      for (int a = 0; a < ctma_pkg::AXES; a++) begin
        offset[a] <= '0;
        scale[a] <= ctma_pkg::SCALE_ONE;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ctma_pkg::CFG_SMOOTH_MODE:   smooth_mode <= cfg_data[1:0];
        ctma_pkg::CFG_WINDOW_LENGTH: window_length <= cfg_data[3:0];
        ctma_pkg::CFG_OFFSET_X:      offset[0] <= cfg_data;
        ctma_pkg::CFG_OFFSET_Y:      offset[1] <= cfg_data;
        ctma_pkg::CFG_OFFSET_Z:      offset[2] <= cfg_data;
        ctma_pkg::CFG_SCALE_X:       scale[0] <= cfg_data;
        ctma_pkg::CFG_SCALE_Y:       scale[1] <= cfg_data;
        ctma_pkg::CFG_SCALE_Z:       scale[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_length == 4'd0) begin
      win = WIN_W'(1);
    end else if (int'(window_length) > WINDOW_MAX) begin
      win = WIN_W'(WINDOW_MAX);
    end else begin
      win = WIN_W'(window_length);
    end
    slot_inc = WIN_W'(slot) + WIN_W'(1);
    trimmed = smooth_mode[1] && (win >= WIN_W'(3));

    diff = $signed({raw[axis][ctma_pkg::RAW_W-1], raw[axis]})
         - $signed({offset[axis][ctma_pkg::RAW_W-1], offset[axis]});
    prod_b = prod + (prod[ctma_pkg::PROD_W-1] ? ctma_pkg::ROUND_BIAS
                                              : ctma_pkg::PROD_W'(0));
    quot_q = prod_b >>> ctma_pkg::FRAC_BITS;
    if (quot_q > ctma_pkg::CAL_MAX) begin
      cal_comb = ctma_pkg::CAL_MAX[CAL_W-1:0];
    end else if (quot_q < ctma_pkg::CAL_MIN) begin
      cal_comb = ctma_pkg::CAL_MIN[CAL_W-1:0];
    end else begin
      cal_comb = quot_q[CAL_W-1:0];
    end

    total_new = totals[axis] - TOT_W'(rd_data) + TOT_W'(cal);

    slot_addr = AW'({slot, 1'b0}) + AW'(slot) + AW'(axis);
    scan_addr = AW'({scan_idx, 1'b0}) + AW'(scan_idx) + AW'(axis);

    if (scan_first) begin
      mx_next = rd_data;
      mn_next = rd_data;
    end else begin
      mx_next = (rd_data > mx) ? rd_data : mx;
      mn_next = (rd_data < mn) ? rd_data : mn;
    end

    rd_en = (state == S_SAT) || (state == S_SCAN);
    rd_addr = (state == S_SCAN) ? scan_addr : slot_addr;
    wr_en = (state == S_OLD);

    div_req.start = (state == S_DIVS);
    div_req.dividend = num;
    div_req.divisor = divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      slot <= '0;
      for (int a = 0; a < ctma_pkg::AXES; a++) begin
        totals[a] <= '0;
      end
    end else begin
      if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (window_clear) begin
        slot <= '0;
        for (int a = 0; a < ctma_pkg::AXES; a++) begin
          totals[a] <= '0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            raw[0] <= s_axis_tdata[15:0];
            raw[1] <= s_axis_tdata[31:16];
            raw[2] <= s_axis_tdata[47:32];
            axis <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= diff * $signed({1'b0, scale[axis]});
          state <= S_SAT;
        end
        S_SAT: begin
          if (smooth_mode == ctma_pkg::MODE_CAL_ONLY) begin
            res[axis] <= cal_comb;
            state <= S_ADV;
          end else begin
            cal <= cal_comb;
            state <= S_OLD;
          end
        end
        S_OLD: begin
          totals[axis] <= total_new;
          tsum <= total_new;
          if (trimmed) begin
            scan_idx <= '0;
            scan_pend <= 1'b0;
            scan_first <= 1'b1;
            state <= S_SCAN;
          end else begin
            num <= ctma_pkg::NUM_SW'(total_new);
            divisor <= ctma_pkg::DIV_W'(win);
            state <= S_DIVS;
          end
        end
        S_SCAN: begin
          if (scan_pend) begin
            mx <= mx_next;
            mn <= mn_next;
            scan_first <= 1'b0;
          end
          scan_pend <= 1'b1;
          if (scan_idx == win - WIN_W'(1)) begin
            state <= S_SEND;
          end else begin
            scan_idx <= scan_idx + WIN_W'(1);
          end
        end
        S_SEND: begin
          mx <= mx_next;
          mn <= mn_next;
          state <= S_TRIM;
        end
        S_TRIM: begin
          num <= ctma_pkg::NUM_SW'(tsum) - ctma_pkg::NUM_SW'(mx)
               - ctma_pkg::NUM_SW'(mn);
          divisor <= ctma_pkg::DIV_W'(win - WIN_W'(2));
          state <= S_DIVS;
        end
        S_DIVS: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (div_rsp.done) begin
            res[axis] <= div_rsp.quotient[CAL_W-1:0];
            state <= S_ADV;
          end
        end
        S_ADV: begin
          if (axis == 2'd2) begin
            if (smooth_mode != ctma_pkg::MODE_CAL_ONLY) begin
              slot <= (slot_inc >= win) ? '0 : slot_inc[SW-1:0];
            end
            state <= S_OUT;
          end else begin
            axis <= axis + 2'd1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {2'b00, res[2], res[1], res[0]};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ctma_window #(
    .DEPTH(DEPTH),
    .DATA_W(CAL_W)
  ) u_window (
    .clk(clk),
    .rst(rst),
    .clear(window_clear),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en(wr_en),
    .wr_addr(slot_addr),
    .wr_data(cal)
  );

  ctma_divider u_divider (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

endmodule
`default_nettype wire

// ===== test/calibrated_trimmed_moving_average_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of calibrated_trimmed_moving_average: samples go in over the
// stream ports, each result is checked against a software filter kept in step.
// Depends on ctma_pkg and the block's RTL.
module calibrated_trimmed_moving_average_tb;
  import ctma_pkg::*;

  localparam int WINDOW_MAX = 10;
  localparam int TOTAL_SAMPLES = 2000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD = 600;
  localparam longint Q_ONE = longint'(1) << FRAC_BITS;
  localparam longint OUT_HI = (longint'(1) << (CAL_W - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) << (CAL_W - 1));
  localparam logic [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W - 1){1'b1}}};
  localparam logic [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_CAL_ONLY = 2'd0,
    MODE_PLAIN = 2'd1,
    MODE_TRIMMED = 2'd2,
    MODE_TRIMMED_ALT = 2'd3
  } smooth_mode_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] z;
    logic signed [RAW_W-1:0] y;
    logic signed [RAW_W-1:0] x;
  } sample_t;

  typedef struct packed {
    logic signed [CAL_W-1:0] z;
    logic signed [CAL_W-1:0] y;
    logic signed [CAL_W-1:0] x;
  } axis_out_t;

  typedef logic [7:0][15:0] reg_image_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // raw_x [15:0], raw_y [31:16], raw_z [47:32]
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // out_x [17:0], out_y [35:18], out_z [53:36], zero [55:54]
  logic [55:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  smooth_mode_t flt_mode;
  logic [3:0] flt_window;
  logic signed [RAW_W-1:0] flt_offset [AXES];
  logic [SCALE_W-1:0] flt_scale [AXES];
  logic signed [CAL_W-1:0] flt_hist [WINDOW_MAX][AXES];
  logic signed [TOT_W-1:0] flt_sum [AXES];
  int flt_slot;
  axis_out_t expected_outputs [$];

  reg_image_t staged_vals = '0;
  logic [7:0] staged_mask = '0;

  int src_gap_pct = 20;
  int sink_stall_pct = 20;
  int long_hold_cycles = 0;
  int fail_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int samples_by_mode [4] = '{0, 0, 0, 0};

  calibrated_trimmed_moving_average #(
    .WINDOW_MAX(WINDOW_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_history();
    foreach (flt_hist[i, a]) flt_hist[i][a] = '0;
    foreach (flt_sum[a]) flt_sum[a] = '0;
    flt_slot = 0;
  endfunction

  // Calibrates one sample, pushes it through the window unless in calibrated-only mode, and returns the filter output.
  function automatic axis_out_t advance_filter(sample_t s);
    logic signed [RAW_W-1:0] raw [AXES];
    longint cal [AXES];
    longint res [AXES];
    longint total, hi, lo, diff, prod;
    int span;
    axis_out_t r;
    raw[0] = s.x;
    raw[1] = s.y;
    raw[2] = s.z;
    if (flt_window == 0) begin
      span = 1;
    end else if (flt_window > WINDOW_MAX) begin
      span = WINDOW_MAX;
    end else begin
      span = int'(flt_window);
    end
    for (int a = 0; a < AXES; a++) begin
      diff = longint'(raw[a]) - longint'(flt_offset[a]);
      prod = diff * longint'(flt_scale[a]);
      cal[a] = prod / Q_ONE;
      if (cal[a] > OUT_HI) cal[a] = OUT_HI;
      if (cal[a] < OUT_LO) cal[a] = OUT_LO;
    end
    if (flt_mode == MODE_CAL_ONLY) begin
      res = cal;
    end else begin
      if (flt_slot >= span) flt_slot = 0;
      for (int a = 0; a < AXES; a++) begin
        total = longint'(flt_sum[a]) - longint'(flt_hist[flt_slot][a]) + cal[a];
        flt_sum[a] = total[TOT_W-1:0];
        flt_hist[flt_slot][a] = cal[a][CAL_W-1:0];
        if (flt_mode != MODE_PLAIN && span >= 3) begin
          hi = flt_hist[0][a];
          lo = hi;
          for (int j = 1; j < span; j++) begin
            if (flt_hist[j][a] > hi) hi = flt_hist[j][a];
            if (flt_hist[j][a] < lo) lo = flt_hist[j][a];
          end
          res[a] = (total - hi - lo) / (span - 2);
        end else begin
          res[a] = total / span;
        end
      end
      flt_slot = (flt_slot + 1 >= span) ? 0 : flt_slot + 1;
    end
    r.x = res[0][CAL_W-1:0];
    r.y = res[1][CAL_W-1:0];
    r.z = res[2][CAL_W-1:0];
    return r;
  endfunction

  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic sample_t make_sample(int x, int y, int z);
    sample_t s;
    s.x = RAW_W'(x);
    s.y = RAW_W'(y);
    s.z = RAW_W'(z);
    return s;
  endfunction

  // Half of the readings lie near the hard iron offset, so that the output does not just saturate.
  function automatic sample_t random_sample();
    logic signed [RAW_W-1:0] v [AXES];
    sample_t s;
    for (int a = 0; a < AXES; a++) begin
      case ($urandom_range(0, 9))
        0: v[a] = RAW_MAX;
        1: v[a] = RAW_MIN;
        2, 3, 4: v[a] = RAW_W'($urandom);
        default: v[a] = flt_offset[a] + RAW_W'($urandom_range(0, 4000)) - RAW_W'(2000);
      endcase
    end
    s.x = v[0];
    s.y = v[1];
    s.z = v[2];
    return s;
  endfunction

  function automatic logic [15:0] random_reg_value(cfg_index_t idx);
    case (idx)
      CFG_SMOOTH_MODE: return 16'($urandom_range(0, 3));
      CFG_WINDOW_LENGTH: begin
        case ($urandom_range(0, 5))
          0: return 16'd0;
          1: return 16'd15;
          2: return 16'(WINDOW_MAX);
          default: return 16'($urandom_range(1, 15));
        endcase
      end
      CFG_OFFSET_X, CFG_OFFSET_Y, CFG_OFFSET_Z: begin
        case ($urandom_range(0, 4))
          0: return RAW_MIN;
          1: return RAW_MAX;
          2: return 16'd0;
          default: return 16'($urandom);
        endcase
      end
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'd0;
          1: return 16'hFFFF;
          2: return SCALE_ONE;
          3, 4: return 16'($urandom_range(SCALE_ONE / 2, SCALE_ONE * 3));
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic void stage_reg(cfg_index_t idx, logic [15:0] value);
    staged_vals[idx] = value;
    staged_mask[idx] = 1'b1;
  endfunction

  task automatic commit_regs();
    cfg_index_t idx;
    for (int i = 0; i < idx.num(); i++) begin
      idx = cfg_index_t'(i);
      if (staged_mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= staged_vals[i];
        do @(posedge clk); while (!cfg_ready);
        case (idx)
          CFG_SMOOTH_MODE: flt_mode = smooth_mode_t'(staged_vals[i][1:0]);
          CFG_WINDOW_LENGTH: begin
            flt_window = staged_vals[i][3:0];
            clear_history();
          end
          CFG_OFFSET_X, CFG_OFFSET_Y, CFG_OFFSET_Z: flt_offset[i - CFG_OFFSET_X] = staged_vals[i];
          default: flt_scale[i - CFG_SCALE_X] = staged_vals[i];
        endcase
        reg_writes++;
      end
    end
    cfg_valid <= 1'b0;
    staged_mask = '0;
  endtask

  task automatic send_sample(input sample_t s);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_length()) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    do @(posedge clk); while (!s_axis_tready);
    samples_by_mode[flt_mode]++;
    expected_outputs.push_back(advance_filter(s));
    samples_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    axis_out_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[3*CAL_W-1:0];
      if (expected_outputs.size() == 0) begin
        $error("result %h arrived with no sample pending", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_outputs.pop_front();
        check_field("out_x", want.x, got.x);
        check_field("out_y", want.y, got.y);
        check_field("out_z", want.z, got.z);
        check_field("pad", 0, longint'(m_axis_tdata[55:3*CAL_W]));
        results_checked++;
      end
    end
  end

  initial begin : sink_pacing
    @(posedge clk);
    forever begin
      if (long_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (long_hold_cycles) @(posedge clk);
        long_hold_cycles = 0;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat (idle_length()) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic test_calibration();
    send_sample(make_sample(32767, -32768, 0));
    send_sample(make_sample(-1, 1, 21845));
    drain_results();
    stage_reg(CFG_OFFSET_X, RAW_MIN);
    stage_reg(CFG_OFFSET_Y, RAW_MAX);
    stage_reg(CFG_OFFSET_Z, 16'd0);
    stage_reg(CFG_SCALE_X, 16'hFFFF);
    stage_reg(CFG_SCALE_Y, 16'hFFFF);
    stage_reg(CFG_SCALE_Z, 16'd0);
    commit_regs();
    send_sample(make_sample(32767, -32768, -12345));
    drain_results();
    // Negative products must truncate toward zero, not toward minus infinity.
    stage_reg(CFG_OFFSET_X, 16'd0);
    stage_reg(CFG_OFFSET_Y, 16'd0);
    stage_reg(CFG_SCALE_X, 16'd1);
    stage_reg(CFG_SCALE_Y, 16'd6144);
    stage_reg(CFG_SCALE_Z, 16'd4095);
    commit_regs();
    send_sample(make_sample(-4097, -3, -1));
    drain_results();
  endtask

  task automatic test_plain_average();
    stage_reg(CFG_SCALE_X, SCALE_ONE);
    stage_reg(CFG_SCALE_Y, SCALE_ONE);
    stage_reg(CFG_SCALE_Z, SCALE_ONE);
    stage_reg(CFG_SMOOTH_MODE, MODE_PLAIN);
    stage_reg(CFG_WINDOW_LENGTH, 16'd3);
    commit_regs();
    send_sample(make_sample(100, -7, 0));
    send_sample(make_sample(200, -8, 1));
    send_sample(make_sample(301, -9, -1));
    send_sample(make_sample(-1000, 5, 2));
    drain_results();
    stage_reg(CFG_WINDOW_LENGTH, 16'd2);
    commit_regs();
    send_sample(make_sample(10, -11, 7));
    drain_results();
  endtask

  task automatic test_trimmed_average();
    stage_reg(CFG_SMOOTH_MODE, MODE_TRIMMED);
    stage_reg(CFG_WINDOW_LENGTH, 16'd4);
    commit_regs();
    send_sample(make_sample(1000, -1000, 5));
    send_sample(make_sample(-50, 40, 7));
    send_sample(make_sample(3, 3, -9));
    send_sample(make_sample(30000, -30000, 1));
    drain_results();
    stage_reg(CFG_WINDOW_LENGTH, 16'd2);
    commit_regs();
    send_sample(make_sample(77, -77, 500));
    send_sample(make_sample(-5, 9, -501));
    drain_results();
    stage_reg(CFG_SMOOTH_MODE, MODE_TRIMMED_ALT);
    stage_reg(CFG_WINDOW_LENGTH, 16'(WINDOW_MAX));
    commit_regs();
    send_sample(make_sample(-20000, 123, 4));
    send_sample(make_sample(15, 20000, -3));
    drain_results();
  endtask

  task automatic test_window_limits();
    stage_reg(CFG_SMOOTH_MODE, MODE_PLAIN);
    stage_reg(CFG_WINDOW_LENGTH, 16'd0);
    commit_regs();
    send_sample(make_sample(-333, 444, -555));
    drain_results();
    stage_reg(CFG_WINDOW_LENGTH, 16'd15);
    commit_regs();
    send_sample(make_sample(9999, -9999, 1));
    send_sample(make_sample(-7, 8, 12345));
    drain_results();
  endtask

  task automatic test_cal_only_keeps_window();
    stage_reg(CFG_WINDOW_LENGTH, 16'd3);
    commit_regs();
    send_sample(make_sample(600, -600, 60));
    drain_results();
    stage_reg(CFG_SMOOTH_MODE, MODE_CAL_ONLY);
    commit_regs();
    send_sample(make_sample(-30000, 30000, -60));
    drain_results();
    stage_reg(CFG_SMOOTH_MODE, MODE_PLAIN);
    commit_regs();
    send_sample(make_sample(300, 0, -300));
    drain_results();
  endtask

  task automatic test_output_backpressure();
    stage_reg(CFG_SMOOTH_MODE, MODE_TRIMMED);
    stage_reg(CFG_WINDOW_LENGTH, 16'(WINDOW_MAX));
    commit_regs();
    src_gap_pct = 0;
    long_hold_cycles = LONG_HOLD;
    repeat (8) send_sample(random_sample());
    drain_results();
    src_gap_pct = 20;
  endtask

  task automatic test_random_phases();
    cfg_index_t idx;
    int batch;
    bit first_phase;
    first_phase = 1'b1;
    while (samples_sent < TOTAL_SAMPLES) begin
      for (int i = 0; i < idx.num(); i++) begin
        idx = cfg_index_t'(i);
        if (first_phase || $urandom_range(0, 1) == 1) stage_reg(idx, random_reg_value(idx));
      end
      first_phase = 1'b0;
      commit_regs();
      case ($urandom_range(0, 2))
        0: src_gap_pct = 0;
        1: src_gap_pct = 15;
        default: src_gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: sink_stall_pct = 0;
        1: sink_stall_pct = 15;
        default: sink_stall_pct = 50;
      endcase
      batch = $urandom_range(20, 150);
      if (batch > TOTAL_SAMPLES - samples_sent) batch = TOTAL_SAMPLES - samples_sent;
      repeat (batch) send_sample(random_sample());
      drain_results();
    end
  endtask

  initial begin : run
    flt_mode = smooth_mode_t'(MODE_RESET);
    flt_window = WINDOW_RESET;
    foreach (flt_offset[a]) flt_offset[a] = '0;
    foreach (flt_scale[a]) flt_scale[a] = SCALE_ONE;
    clear_history();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_calibration();
    test_plain_average();
    test_trimmed_average();
    test_window_limits();
    test_cal_only_keeps_window();
    test_output_backpressure();
    test_random_phases();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples (%0d calibrated only, %0d plain, %0d trimmed, %0d mode three),",
             samples_sent, samples_by_mode[MODE_CAL_ONLY], samples_by_mode[MODE_PLAIN],
             samples_by_mode[MODE_TRIMMED], samples_by_mode[MODE_TRIMMED_ALT]);
    $display("checked %0d results in order, issued %0d register writes, %0d failures.",
             results_checked, reg_writes, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("Timed out with %0d results outstanding.", expected_outputs.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ctma_pkg.sv
rtl/ctma_divider.sv
rtl/ctma_window.sv
rtl/calibrated_trimmed_moving_average.sv
test/calibrated_trimmed_moving_average_tb.sv
